>>> design/imugs_pkg.sv
// Shared types and constants for the IMU gesture servo stepper.
package imugs_pkg;

  // Sensor frame bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] KIND_GYRO  = 8'h52;
  localparam logic [7:0] KIND_ACCEL = 8'h51;

  // Servo limits and claw pulses
  localparam logic [11:0] BASE_MAX  = 12'd2300;
  localparam logic [11:0] BASE_MIN  = 12'd600;
  localparam logic [11:0] LEFT_MAX  = 12'd1400;
  localparam logic [11:0] LEFT_MIN  = 12'd1300;
  localparam logic [11:0] RIGHT_MAX = 12'd2300;
  localparam logic [11:0] RIGHT_MIN = 12'd1000;
  localparam logic [11:0] CLAW_OPEN = 12'd1300;
  localparam logic [11:0] CLAW_SHUT = 12'd900;
  localparam logic [11:0] BASE_RST  = 12'd1500;
  localparam logic [11:0] LEFT_RST  = 12'd1300;
  localparam logic [11:0] RIGHT_RST = 12'd1300;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLICK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_STEP = 3'd5;

  // Decoded request passed from the parser to the executor
  typedef enum logic [2:0] {
    OP_BYTE,   // byte with no word to store
    OP_GX,     // store gyro X
    OP_GY,     // store gyro Y
    OP_AZ,     // store accel Z
    OP_TICK    // control tick
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] word;
  } cmd_t;

endpackage

>>> design/imugs_front.sv
// Front end: accepts requests, runs the frame parser, emits decoded commands.
module imugs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                action_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output imugs_pkg::cmd_t     push_cmd_o
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic       kind_q, kind_d;   // 1 gyro, 0 accel
  logic [2:0] idx_q, idx_d;
  logic [7:0] hold_q, hold_d;
  logic       take;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign push_o     = take;

  always_comb begin
    phase_d         = phase_q;
    kind_d          = kind_q;
    idx_d           = idx_q;
    hold_d          = hold_q;
    push_cmd_o.op   = imugs_pkg::OP_BYTE;
    push_cmd_o.word = {rx_byte_i, hold_q};
    if (action_i) begin
      push_cmd_o.op = imugs_pkg::OP_TICK;
    end else begin
      case (phase_q)
        PH_TYPE: begin
          if (rx_byte_i == imugs_pkg::KIND_GYRO || rx_byte_i == imugs_pkg::KIND_ACCEL) begin
            kind_d  = (rx_byte_i == imugs_pkg::KIND_GYRO);
            idx_d   = 3'd0;
            phase_d = PH_PAY;
          end else if (rx_byte_i != imugs_pkg::HDR_BYTE) begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAY: begin
          if (!idx_q[0]) begin
            hold_d = rx_byte_i;
          end else if (kind_q) begin
            if (idx_q == 3'd1) push_cmd_o.op = imugs_pkg::OP_GX;
            else if (idx_q == 3'd3) push_cmd_o.op = imugs_pkg::OP_GY;
          end else if (idx_q == 3'd5) begin
            push_cmd_o.op = imugs_pkg::OP_AZ;
          end
          if (idx_q >= 3'd5) begin
            phase_d = PH_HUNT;
            idx_d   = 3'd0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        default: begin
          // hunting; the spare phase code hunts too
          phase_d = (rx_byte_i == imugs_pkg::HDR_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      kind_q  <= 1'b0;
      idx_q   <= 3'd0;
      hold_q  <= 8'd0;
    end else if (take) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      hold_q  <= hold_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd5)
    else $error("payload index out of range");

endmodule

>>> design/imugs_queue.sv
// Two-entry command queue between parser and executor.
module imugs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  imugs_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output imugs_pkg::cmd_t cmd_o
);

  imugs_pkg::cmd_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

>>> design/imugs_back.sv
// Back end: gyro/accel state, flick detector, servo stepping and result register.
module imugs_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [imugs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [imugs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 q_valid_i,
  input  imugs_pkg::cmd_t                      q_cmd_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [11:0]                          base_pulse_o,
  output logic [11:0]                          right_pulse_o,
  output logic [11:0]                          left_pulse_o,
  output logic [11:0]                          claw_pulse_o,
  output logic                                 negative_tilt_led_o,
  output logic                                 positive_tilt_led_o
);

  logic [14:0] rate_lo_q, rate_hi_q, flick_thr_q;
  logic [7:0]  base_step_q, left_step_q, right_step_q;

  logic [15:0] gx_q, gx_d, gy_q, gy_d, az_q, az_d;
  logic [1:0]  flick_q, flick_d;
  logic [11:0] base_q, base_d, left_q, left_d, right_q, right_d;
  logic        claw_q, claw_d;
  logic        out_valid_q, out_valid_d;

  logic [1:0]         bx, by, bout;   // {positive band, negative band}
  logic signed [16:0] z, t;
  logic signed [13:0] b_up, b_dn, l_up, l_dn, r_up, r_dn;

  // {v in (lo, hi), v in (-hi, -lo)}
  function automatic logic [1:0] tilt(input logic [15:0] raw,
                                      input logic [14:0] lo,
                                      input logic [14:0] hi);
    logic signed [16:0] v, l, h;
    v = {raw[15], raw};
    l = {2'b00, lo};
    h = {2'b00, hi};
    tilt = {(v > l) && (v < h), (v < -l) && (v > -h)};
  endfunction

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign bx = tilt(gx_q, rate_lo_q, rate_hi_q);
  assign by = tilt(gy_q, rate_lo_q, rate_hi_q);

  assign b_up = $signed({2'b00, base_q}) + $signed({6'd0, base_step_q});
  assign b_dn = $signed({2'b00, base_q}) - $signed({6'd0, base_step_q});
  assign l_up = $signed({2'b00, left_q}) + $signed({6'd0, left_step_q});
  assign l_dn = $signed({2'b00, left_q}) - $signed({6'd0, left_step_q});
  assign r_up = $signed({2'b00, right_q}) + $signed({6'd0, right_step_q});
  assign r_dn = $signed({2'b00, right_q}) - $signed({6'd0, right_step_q});

  always_comb begin
    gx_d    = gx_q;
    gy_d    = gy_q;
    az_d    = az_q;
    flick_d = flick_q;
    base_d  = base_q;
    left_d  = left_q;
    right_d = right_q;
    claw_d  = claw_q;
    t       = {2'b00, flick_thr_q};
    z       = '0;
    case (q_cmd_i.op)
      imugs_pkg::OP_GX: gx_d = q_cmd_i.word;
      imugs_pkg::OP_GY: gy_d = q_cmd_i.word;
      imugs_pkg::OP_AZ: az_d = q_cmd_i.word;
      default: ;
    endcase
    if (q_cmd_i.op == imugs_pkg::OP_TICK) begin
      if (flick_q == 2'd2) begin
        claw_d  = !claw_q;
        flick_d = 2'd0;
      end
      if (bx[0]) begin
        base_d = (b_up >= $signed({2'b00, imugs_pkg::BASE_MAX})) ?
                 imugs_pkg::BASE_MAX : b_up[11:0];
      end else if (bx[1]) begin
        base_d = (b_dn <= $signed({2'b00, imugs_pkg::BASE_MIN})) ?
                 imugs_pkg::BASE_MIN : b_dn[11:0];
      end
      if (by[1]) begin
        left_d  = (l_dn <= $signed({2'b00, imugs_pkg::LEFT_MIN})) ?
                  imugs_pkg::LEFT_MIN : l_dn[11:0];
        right_d = (r_dn <= $signed({2'b00, imugs_pkg::RIGHT_MIN})) ?
                  imugs_pkg::RIGHT_MIN : r_dn[11:0];
      end else if (by[0]) begin
        left_d  = (l_up >= $signed({2'b00, imugs_pkg::LEFT_MAX})) ?
                  imugs_pkg::LEFT_MAX : l_up[11:0];
        right_d = (r_up >= $signed({2'b00, imugs_pkg::RIGHT_MAX})) ?
                  imugs_pkg::RIGHT_MAX : r_up[11:0];
      end
    end else begin
      // flick detector steps after every byte, on the updated accel Z
      z = {az_d[15], az_d};
      if (flick_q == 2'd0 && z > t) flick_d = 2'd1;
      if (flick_d == 2'd1 && z < -t) flick_d = 2'd2;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_lo_q    <= 15'd819;
      rate_hi_q    <= 15'd4916;
      flick_thr_q  <= 15'd1024;
      base_step_q  <= 8'd50;
      left_step_q  <= 8'd10;
      right_step_q <= 8'd130;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imugs_pkg::CFG_RATE_LOW:   rate_lo_q    <= cfg_data_i;
        imugs_pkg::CFG_RATE_HIGH:  rate_hi_q    <= cfg_data_i;
        imugs_pkg::CFG_FLICK:      flick_thr_q  <= cfg_data_i;
        imugs_pkg::CFG_BASE_STEP:  base_step_q  <= cfg_data_i[7:0];
        imugs_pkg::CFG_LEFT_STEP:  left_step_q  <= cfg_data_i[7:0];
        imugs_pkg::CFG_RIGHT_STEP: right_step_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q        <= 16'd0;
      gy_q        <= 16'd0;
      az_q        <= 16'd0;
      flick_q     <= 2'd0;
      base_q      <= imugs_pkg::BASE_RST;
      left_q      <= imugs_pkg::LEFT_RST;
      right_q     <= imugs_pkg::RIGHT_RST;
      claw_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        gx_q    <= gx_d;
        gy_q    <= gy_d;
        az_q    <= az_d;
        flick_q <= flick_d;
        base_q  <= base_d;
        left_q  <= left_d;
        right_q <= right_d;
        claw_q  <= claw_d;
      end
    end
  end

  // State registers double as the result register: they only move on a pop,
  // and a pop never happens while a result is stalled.
  assign bout                = tilt(gx_q, rate_lo_q, rate_hi_q);
  assign out_valid_o         = out_valid_q;
  assign base_pulse_o        = base_q;
  assign right_pulse_o       = right_q;
  assign left_pulse_o        = left_q;
  assign claw_pulse_o        = claw_q ? imugs_pkg::CLAW_OPEN : imugs_pkg::CLAW_SHUT;
  assign negative_tilt_led_o = bout[1];
  assign positive_tilt_led_o = bout[0];

  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q >= imugs_pkg::BASE_MIN && base_q <= imugs_pkg::BASE_MAX)
    else $error("base position out of range");

  a_arm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q >= imugs_pkg::LEFT_MIN && left_q <= imugs_pkg::LEFT_MAX &&
    right_q >= imugs_pkg::RIGHT_MIN && right_q <= imugs_pkg::RIGHT_MAX)
    else $error("arm position out of range");

  a_tick_clears_flick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_cmd_i.op == imugs_pkg::OP_TICK && flick_q == 2'd2) |=>
    (flick_q == 2'd0))
    else $error("flick detector not restarted by tick");

endmodule

>>> design/imu_gesture_servo_stepper.sv
// Top level of the IMU gesture servo stepper: parser, command queue, executor.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o   | action_i, rx_byte_i
//  out     | out_valid_o / out_stall_i | base/right/left/claw pulse, two tilt LEDs
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i is low; a taken request is written
// into the queue, then popped into the result registers, which present it.
// The two-entry queue lets the parser keep taking requests while a result is stalled;
// in_stall_o rises only once the queue is full.
// Reset restores thresholds, steps and servo positions at once; no clearing pass.
module imu_gesture_servo_stepper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [11:0]                      base_pulse_o,
  output logic [11:0]                      right_pulse_o,
  output logic [11:0]                      left_pulse_o,
  output logic [11:0]                      claw_pulse_o,
  output logic                             negative_tilt_led_o,
  output logic                             positive_tilt_led_o,
  input  logic                             cfg_we_i,
  input  logic [imugs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [imugs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic            push, full, pop, q_valid;
  imugs_pkg::cmd_t push_cmd, q_cmd;

  imugs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  imugs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  imugs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .q_valid_i           (q_valid),
    .q_cmd_i             (q_cmd),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .base_pulse_o        (base_pulse_o),
    .right_pulse_o       (right_pulse_o),
    .left_pulse_o        (left_pulse_o),
    .claw_pulse_o        (claw_pulse_o),
    .negative_tilt_led_o (negative_tilt_led_o),
    .positive_tilt_led_o (positive_tilt_led_o)
  );

endmodule

>>> test/imu_gesture_servo_stepper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IMU gesture servo stepper: sensor bytes and ticks in, pulses out.
module imu_gesture_servo_stepper_tb;

  typedef enum logic [1:0] {PH_HUNT, PH_TYPE, PH_PAYLOAD} parse_phase_e;
  typedef enum logic [1:0] {FL_IDLE, FL_ARMED, FL_DONE} flick_stage_e;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  // indexes past the last register, written to show they are ignored
  localparam logic [imugs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [imugs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } sensor_req_t;

  typedef struct packed {
    logic [11:0] base;
    logic [11:0] right;
    logic [11:0] left;
    logic [11:0] claw;
    logic        neg_led;
    logic        pos_led;
  } servo_out_t;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic                             action_i    = 1'b0;
  logic [7:0]                       rx_byte_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [11:0]                      base_pulse_o;
  logic [11:0]                      right_pulse_o;
  logic [11:0]                      left_pulse_o;
  logic [11:0]                      claw_pulse_o;
  logic                             negative_tilt_led_o;
  logic                             positive_tilt_led_o;
  logic                             cfg_we_i    = 1'b0;
  logic [imugs_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [imugs_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  imu_gesture_servo_stepper uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .base_pulse_o        (base_pulse_o),
    .right_pulse_o       (right_pulse_o),
    .left_pulse_o        (left_pulse_o),
    .claw_pulse_o        (claw_pulse_o),
    .negative_tilt_led_o (negative_tilt_led_o),
    .positive_tilt_led_o (positive_tilt_led_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sensor_req_t sensor_q[$];
  servo_out_t  pulse_q[$];
  int          queued     = 0;
  int          mismatches = 0;
  logic        in_taken   = 1'b0;
  logic        calm       = 1'b0;

  // predictor copy of the registers
  logic [14:0] c_rate_low, c_rate_high, c_flick;
  logic [7:0]  c_base_step, c_left_step, c_right_step;

  // predictor copy of the state
  parse_phase_e p_phase;
  flick_stage_e p_flick;
  logic         p_gyro_kind;
  logic [2:0]   p_index;
  logic [7:0]   p_low_hold;
  logic [15:0]  p_gyro_x, p_gyro_y, p_accel_z;
  int           p_base, p_left, p_right;
  logic         p_claw_open;

  // +1 in the positive tilt band, -1 in the negative band, 0 outside
  function automatic int rate_band(logic [15:0] raw);
    int v, lo, hi;
    v  = $signed(raw);
    lo = c_rate_low;
    hi = c_rate_high;
    if (v > lo && v < hi) return 1;
    if (v < -lo && v > -hi) return -1;
    return 0;
  endfunction

  function automatic servo_out_t servo_predict(logic act, logic [7:0] b);
    servo_out_t  r;
    int          bx, by, z, t, bs, ls, rs;
    logic [15:0] word;
    if (act == ACT_TICK) begin
      bx = rate_band(p_gyro_x);
      by = rate_band(p_gyro_y);
      bs = c_base_step;
      ls = c_left_step;
      rs = c_right_step;
      if (p_flick == FL_DONE) begin
        p_claw_open = !p_claw_open;
        p_flick     = FL_IDLE;
      end
      if (bx < 0) begin
        p_base += bs;
        if (p_base >= int'(imugs_pkg::BASE_MAX)) p_base = int'(imugs_pkg::BASE_MAX);
      end else if (bx > 0) begin
        p_base -= bs;
        if (p_base <= int'(imugs_pkg::BASE_MIN)) p_base = int'(imugs_pkg::BASE_MIN);
      end
      if (by > 0) begin
        p_left  -= ls;
        p_right -= rs;
        if (p_left <= int'(imugs_pkg::LEFT_MIN)) p_left = int'(imugs_pkg::LEFT_MIN);
        if (p_right <= int'(imugs_pkg::RIGHT_MIN)) p_right = int'(imugs_pkg::RIGHT_MIN);
      end else if (by < 0) begin
        p_left  += ls;
        p_right += rs;
        if (p_left >= int'(imugs_pkg::LEFT_MAX)) p_left = int'(imugs_pkg::LEFT_MAX);
        if (p_right >= int'(imugs_pkg::RIGHT_MAX)) p_right = int'(imugs_pkg::RIGHT_MAX);
      end
    end else begin
      case (p_phase)
        PH_TYPE: begin
          if (b == imugs_pkg::KIND_GYRO || b == imugs_pkg::KIND_ACCEL) begin
            p_gyro_kind = (b == imugs_pkg::KIND_GYRO);
            p_index     = '0;
            p_phase     = PH_PAYLOAD;
          end else if (b != imugs_pkg::HDR_BYTE) begin
            p_phase = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (!p_index[0]) begin
            p_low_hold = b;
          end else begin
            word = {b, p_low_hold};
            if (p_gyro_kind) begin
              if (p_index == 3'd1) p_gyro_x = word;
              else if (p_index == 3'd3) p_gyro_y = word;
            end else if (p_index == 3'd5) begin
              p_accel_z = word;
            end
          end
          if (p_index >= 3'd5) begin
            p_phase = PH_HUNT;
            p_index = '0;
          end else begin
            p_index = p_index + 3'd1;
          end
        end
        default: p_phase = (b == imugs_pkg::HDR_BYTE) ? PH_TYPE : PH_HUNT;
      endcase
      z = $signed(p_accel_z);
      t = c_flick;
      if (p_flick == FL_IDLE && z > t) p_flick = FL_ARMED;
      if (p_flick == FL_ARMED && z < -t) p_flick = FL_DONE;
    end
    bx        = rate_band(p_gyro_x);
    r.base    = p_base[11:0];
    r.right   = p_right[11:0];
    r.left    = p_left[11:0];
    r.claw    = p_claw_open ? imugs_pkg::CLAW_OPEN : imugs_pkg::CLAW_SHUT;
    r.neg_led = (bx > 0);
    r.pos_led = (bx < 0);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: next request goes out on the falling edge once the last one was taken
  always @(negedge clk_i) begin
    sensor_req_t req;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (sensor_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
        req = sensor_q.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= req.action;
        rx_byte_i  <= req.rx_byte;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 12);
  end

  // monitor: results are checked before the request of this edge is predicted
  always @(posedge clk_i) begin
    servo_out_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pulse_q.size() == 0) begin
          $error("result with no request pending: base_pulse %0d", base_pulse_o);
          mismatches++;
        end else begin
          want = pulse_q.pop_front();
          check_field("base_pulse", want.base, base_pulse_o);
          check_field("right_pulse", want.right, right_pulse_o);
          check_field("left_pulse", want.left, left_pulse_o);
          check_field("claw_pulse", want.claw, claw_pulse_o);
          check_field("negative_tilt_led", want.neg_led, negative_tilt_led_o);
          check_field("positive_tilt_led", want.pos_led, positive_tilt_led_o);
        end
      end
      if (in_valid_i && !in_stall_o) pulse_q.push_back(servo_predict(action_i, rx_byte_i));
    end
  end

  task automatic push_req(logic act, logic [7:0] b);
    sensor_req_t req;
    req.action  = act;
    req.rx_byte = b;
    sensor_q.push_back(req);
    queued++;
  endtask

  task automatic push_frame(logic [7:0] kind, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    push_req(ACT_BYTE, imugs_pkg::HDR_BYTE);
    push_req(ACT_BYTE, kind);
    push_req(ACT_BYTE, x[7:0]);
    push_req(ACT_BYTE, x[15:8]);
    push_req(ACT_BYTE, y[7:0]);
    push_req(ACT_BYTE, y[15:8]);
    push_req(ACT_BYTE, z[7:0]);
    push_req(ACT_BYTE, z[15:8]);
  endtask

  // gyro words clustered on the band edges of the current thresholds
  function automatic logic [15:0] rate_value();
    int lo, hi, v;
    lo = c_rate_low;
    hi = c_rate_high;
    case ($urandom_range(6))
      0: v = $urandom_range(65535);
      1: v = lo + $urandom_range(2) - 1;
      2: v = hi + $urandom_range(2) - 1;
      3: v = 0;
      4: v = $urandom_range(1) ? 32767 : 32768;
      default: v = (hi > lo + 1) ? lo + 1 + $urandom_range(hi - lo - 2) : $urandom_range(65535);
    endcase
    if ($urandom_range(1)) v = -v;
    return v[15:0];
  endfunction

  function automatic logic [15:0] flick_value();
    int t, v;
    t = c_flick;
    case ($urandom_range(4))
      0: v = $urandom_range(65535);
      1: v = t + $urandom_range(2) - 1;
      2: v = $urandom_range(1) ? 32767 : 32768;
      default: v = t + $urandom_range(3000);
    endcase
    if ($urandom_range(1)) v = -v;
    return v[15:0];
  endfunction

  task automatic fill_random(int n);
    int stop, r;
    stop = queued + n;
    while (queued < stop) begin
      r = $urandom_range(99);
      if (r < 35) begin
        push_frame(imugs_pkg::KIND_GYRO, rate_value(), rate_value(),
                   16'($urandom_range(65535)));
      end else if (r < 55) begin
        push_frame(imugs_pkg::KIND_ACCEL, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), flick_value());
      end else if (r < 80) begin
        repeat ($urandom_range(1, 3)) push_req(ACT_TICK, 8'($urandom_range(255)));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3)) push_req(ACT_BYTE, 8'($urandom_range(255)));
      end else if (r < 95) begin
        // broken frames: repeated headers, bad type, cut-short payload
        push_req(ACT_BYTE, imugs_pkg::HDR_BYTE);
        case ($urandom_range(2))
          0: begin
            repeat ($urandom_range(1, 3)) push_req(ACT_BYTE, imugs_pkg::HDR_BYTE);
            push_req(ACT_BYTE, $urandom_range(1) ? imugs_pkg::KIND_GYRO : imugs_pkg::KIND_ACCEL);
          end
          1: push_req(ACT_BYTE, 8'($urandom_range(255)));
          default: begin
            push_req(ACT_BYTE, imugs_pkg::KIND_GYRO);
            repeat ($urandom_range(1, 5)) push_req(ACT_BYTE, 8'($urandom_range(255)));
          end
        endcase
      end else begin
        // header and type codes inside the payload
        push_frame($urandom_range(1) ? imugs_pkg::KIND_GYRO : imugs_pkg::KIND_ACCEL,
                   {imugs_pkg::KIND_GYRO, imugs_pkg::HDR_BYTE},
                   {imugs_pkg::HDR_BYTE, imugs_pkg::KIND_ACCEL},
                   {imugs_pkg::HDR_BYTE, imugs_pkg::HDR_BYTE});
      end
    end
  endtask

  // all requests taken and answered, then the pipeline is left to settle
  task automatic drain();
    while (sensor_q.size() != 0 || in_valid_i || pulse_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [imugs_pkg::CFG_IDX_W-1:0] idx,
                           logic [imugs_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      imugs_pkg::CFG_RATE_LOW:   c_rate_low   = value[14:0];
      imugs_pkg::CFG_RATE_HIGH:  c_rate_high  = value[14:0];
      imugs_pkg::CFG_FLICK:      c_flick      = value[14:0];
      imugs_pkg::CFG_BASE_STEP:  c_base_step  = value[7:0];
      imugs_pkg::CFG_LEFT_STEP:  c_left_step  = value[7:0];
      imugs_pkg::CFG_RIGHT_STEP: c_right_step = value[7:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(int lo, int hi, int fl, int bs, int ls, int rs);
    cfg_write(imugs_pkg::CFG_RATE_LOW, lo[14:0]);
    cfg_write(imugs_pkg::CFG_RATE_HIGH, hi[14:0]);
    cfg_write(imugs_pkg::CFG_FLICK, fl[14:0]);
    cfg_write(imugs_pkg::CFG_BASE_STEP, bs[14:0]);
    cfg_write(imugs_pkg::CFG_LEFT_STEP, ls[14:0]);
    cfg_write(imugs_pkg::CFG_RIGHT_STEP, rs[14:0]);
  endtask

  initial begin
    c_rate_low   = 15'd819;
    c_rate_high  = 15'd4916;
    c_flick      = 15'd1024;
    c_base_step  = 8'd50;
    c_left_step  = 8'd10;
    c_right_step = 8'd130;
    p_phase      = PH_HUNT;
    p_flick      = FL_IDLE;
    p_gyro_kind  = 1'b0;
    p_index      = '0;
    p_low_hold   = '0;
    p_gyro_x     = '0;
    p_gyro_y     = '0;
    p_accel_z    = '0;
    p_base       = int'(imugs_pkg::BASE_RST);
    p_left       = int'(imugs_pkg::LEFT_RST);
    p_right      = int'(imugs_pkg::RIGHT_RST);
    p_claw_open  = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset settings: tilt in both senses, headers in payload,
    // repeated header, full flick then the claw toggle
    push_req(ACT_TICK, 8'h00);
    push_frame(imugs_pkg::KIND_GYRO, 16'd1000, 16'hFC18,
               {imugs_pkg::HDR_BYTE, imugs_pkg::HDR_BYTE});
    push_req(ACT_TICK, 8'hFF);
    push_req(ACT_BYTE, imugs_pkg::HDR_BYTE);
    push_frame(imugs_pkg::KIND_ACCEL, 16'h8000, 16'hFFFF, 16'h7FFF);
    push_frame(imugs_pkg::KIND_ACCEL, 16'h0000, 16'h0000, 16'h8000);
    push_req(ACT_BYTE, imugs_pkg::HDR_BYTE);
    push_req(ACT_BYTE, 8'h33);
    push_req(ACT_TICK, 8'h00);
    drain();

    cfg_all($urandom_range(200, 1500), $urandom_range(2000, 9000), $urandom_range(100, 4000),
            $urandom_range(255), $urandom_range(255), $urandom_range(255));
    fill_random(260);
    drain();

    // widest bands, biggest steps; no idling on either side here
    cfg_all(0, 32767, 0, 255, 255, 255);
    calm = 1'b1;
    fill_random(260);
    drain();
    calm = 1'b0;

    // no band can match, flick never arms
    cfg_all(32767, 0, 32767, 0, 0, 0);
    fill_random(150);
    drain();

    // equal thresholds; upper data bits on the step registers must be dropped
    cfg_all(1500, 1500, 300, 15'h7F05, 15'h7F3C, 15'h0A11);
    cfg_write(CFG_SPARE_A, 15'h7FFF);
    cfg_write(CFG_SPARE_B, 15'h0000);
    fill_random(200);
    drain();

    cfg_all(100, 20000, 500, 1, 7, 90);
    fill_random(400);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
design/imugs_pkg.sv
design/imugs_front.sv
design/imugs_queue.sv
design/imugs_back.sv
design/imu_gesture_servo_stepper.sv
test/imu_gesture_servo_stepper_tb.sv
